### design/bmrb_pkg.sv
// Shared types and constants of the binary mask run-boundary unit.
`timescale 1ns / 1ps

package bmrb_pkg;

  localparam int IMAGE_WIDTH_W  = 11;
  localparam int IMAGE_HEIGHT_W = 13;
  localparam int ROW_W          = 12;
  localparam int HEIGHT_LIMIT   = 4096;
  localparam int WIDTH_RESET    = 512;
  localparam int HEIGHT_RESET   = 512;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;

  // item opcodes
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic opcode;
    logic pixel_in;
  } pix_item_t;

  typedef struct packed {
    logic boundary_mark;
    logic slice_last;
  } res_item_t;

  // what the scan control hands to the mark stage with each issued read
  typedef struct packed {
    logic drain;
    logic pixel;
    logic first_row;
    logic left;
    logic x_zero;
    logic x_last;
  } scan_item_t;

endpackage

### design/bmrb_line_ram.sv
// One-bit line store: one write and one registered read port, write data forwarded.
`timescale 1ns / 1ps

module bmrb_line_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic          rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // forward a write to the same entry so the read sees the new value
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

### design/bmrb_scan_ctrl.sv
// Raster position tracking and read issue for the run-boundary unit.
`timescale 1ns / 1ps

module bmrb_scan_ctrl
  import bmrb_pkg::*;
#(
  parameter int XW = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 restart,
  input  logic                 accept,
  input  pix_item_t            pix,
  input  logic [XW:0]          eff_width,
  input  logic [IMAGE_HEIGHT_W-1:0] eff_height,
  output logic                 issue,
  output scan_item_t           issue_item,
  output logic [XW-1:0]        issue_addr
);

  logic [XW-1:0]    col;
  logic [ROW_W-1:0] row;
  logic             left_pixel;
  logic             draining;
  logic             x_last;
  logic             row_last;

  assign x_last   = (({1'b0, col} + (XW+1)'(1)) == eff_width);
  assign row_last = (({1'b0, row} + IMAGE_HEIGHT_W'(1)) == eff_height);

  always_comb begin
    if (pix.opcode == OP_DRAIN) begin
      issue = accept && draining;
    end else begin
      issue = accept && !draining;
    end
    issue_item.drain     = (pix.opcode == OP_DRAIN);
    issue_item.pixel     = pix.pixel_in;
    issue_item.first_row = (row == '0);
    issue_item.left      = left_pixel;
    issue_item.x_zero    = (col == '0);
    issue_item.x_last    = x_last;
    issue_addr           = col;
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col        <= '0;
      row        <= '0;
      left_pixel <= 1'b0;
      draining   <= 1'b0;
    end else if (accept) begin
      case (pix.opcode)
        OP_DRAIN: begin
          if (draining) begin
            if (x_last) begin
              col      <= '0;
              row      <= '0;
              draining <= 1'b0;
            end else begin
              col <= col + XW'(1);
            end
          end
        end
        OP_PIXEL: begin
          if (!draining) begin
            if (x_last) begin
              col        <= '0;
              left_pixel <= 1'b0;
              if (row_last) begin
                draining <= 1'b1;
              end else begin
                row <= row + ROW_W'(1);
              end
            end else begin
              col        <= col + XW'(1);
              left_pixel <= pix.pixel_in;
            end
          end
        end
        default: begin
          col <= col;
        end
      endcase
    end
  end

endmodule

### design/bmrb_mark_stage.sv
// Mark evaluation, line store write-back and result register.
`timescale 1ns / 1ps

module bmrb_mark_stage
  import bmrb_pkg::*;
#(
  parameter int XW = 10
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          issue,
  input  scan_item_t    issue_item,
  input  logic [XW-1:0] issue_addr,
  input  logic          rd_above,
  input  logic          rd_pend,
  output logic          hold,
  output logic          above_we,
  output logic [XW-1:0] above_waddr,
  output logic          above_wdata,
  output logic          pend_we,
  output logic [XW-1:0] pend_waddr,
  output logic          pend_wdata,
  output logic          res_valid,
  input  logic          res_stall,
  output res_item_t     res
);

  logic          s1_valid;
  scan_item_t    s1;
  logic [XW-1:0] s1_addr;
  logic          prev_part;
  logic          last_pend;
  logic          s1_res;
  logic          s1_go;
  logic          fire;
  logic          pend_old;
  logic          part;
  logic          mark;

  assign s1_res = s1.drain || !s1.first_row;
  assign s1_go  = !s1_valid || !s1_res || !res_valid || !res_stall;
  assign hold   = s1_valid && !s1_go;
  assign fire   = s1_valid && s1_go;

  always_comb begin
    pend_old = s1.x_last ? last_pend : rd_pend;
    part     = s1.pixel && (s1.x_zero || !s1.left || s1.first_row || !rd_above);
    if (s1.drain) begin
      mark = pend_old;
    end else begin
      mark = pend_old | (rd_above & !s1.pixel);
    end
    above_we    = fire && !s1.drain;
    above_waddr = s1_addr;
    above_wdata = s1.pixel;
    // the left neighbour's mark, but for the lower-neighbour term, is complete once this pixel is known
    pend_we     = fire && !s1.drain && !s1.x_zero;
    pend_waddr  = s1_addr - XW'(1);
    pend_wdata  = prev_part | (s1.left & !s1.pixel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_go) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s1      <= issue_item;
      s1_addr <= issue_addr;
    end
    if (fire && !s1.drain) begin
      prev_part <= part;
      if (s1.x_last) begin
        last_pend <= part;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire && s1_res) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_res) begin
      res.boundary_mark <= mark;
      res.slice_last    <= s1.drain && s1.x_last;
    end
  end

endmodule

### design/binary_mask_run_boundary_unit.sv
// Top level of the binary mask run-boundary unit.
`timescale 1ns / 1ps
// Pipeline: the transfer of the pixel or drain item that completes a result reads the line
//   stores and registers the item in the mark stage, which then loads the output register.
// Throughput: one item per cycle, bounded by the single read and write port of each
//   line store; the input stalls only while a finished result waits on a stalled output.
// Reset: clears position counters, draining flag and valid flags; the line stores are
//   not cleared, since the first row of every slice rewrites each entry before it is read.

module binary_mask_run_boundary_unit
  import bmrb_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               pix_valid,
  output logic               pix_stall,
  input  pix_item_t          pix,
  output logic               res_valid,
  input  logic               res_stall,
  output res_item_t          res
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int EW = XW + 1;
  localparam int WIDTH_RESET_EFF = (MAX_WIDTH < WIDTH_RESET) ? MAX_WIDTH : WIDTH_RESET;

  // configuration registers as written, and their clamped working values
  logic [IMAGE_WIDTH_W-1:0]  image_width;
  logic [IMAGE_HEIGHT_W-1:0] image_height;
  logic [EW-1:0]             eff_width;
  logic [IMAGE_HEIGHT_W-1:0] eff_height;
  logic                      cfg_write;

  logic          accept;
  logic          issue;
  scan_item_t    issue_item;
  logic [XW-1:0] issue_addr;
  logic          rd_above;
  logic          rd_pend;
  logic          above_we;
  logic [XW-1:0] above_waddr;
  logic          above_wdata;
  logic          pend_we;
  logic [XW-1:0] pend_waddr;
  logic          pend_wdata;

  // APB: no wait states, register selected by paddr[2]
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    if (paddr[2] == REG_IMAGE_HEIGHT) begin
      prdata = PDATA_W'(image_height);
    end else begin
      prdata = PDATA_W'(image_width);
    end
  end

  // a write takes effect at once; clamp here so the scan sees legal bounds only
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_W'(WIDTH_RESET);
      image_height <= IMAGE_HEIGHT_W'(HEIGHT_RESET);
      eff_width    <= EW'(WIDTH_RESET_EFF);
      eff_height   <= IMAGE_HEIGHT_W'(HEIGHT_RESET);
    end else if (cfg_write) begin
      case (paddr[2])
        REG_IMAGE_WIDTH: begin
          image_width <= pwdata[IMAGE_WIDTH_W-1:0];
          if (pwdata[IMAGE_WIDTH_W-1:0] == '0) begin
            eff_width <= EW'(1);
          end else if (32'(pwdata[IMAGE_WIDTH_W-1:0]) > 32'(MAX_WIDTH)) begin
            eff_width <= EW'(MAX_WIDTH);
          end else begin
            eff_width <= EW'(pwdata[IMAGE_WIDTH_W-1:0]);
          end
        end
        REG_IMAGE_HEIGHT: begin
          image_height <= pwdata[IMAGE_HEIGHT_W-1:0];
          if (pwdata[IMAGE_HEIGHT_W-1:0] == '0) begin
            eff_height <= IMAGE_HEIGHT_W'(1);
          end else if (32'(pwdata[IMAGE_HEIGHT_W-1:0]) > 32'(HEIGHT_LIMIT)) begin
            eff_height <= IMAGE_HEIGHT_W'(HEIGHT_LIMIT);
          end else begin
            eff_height <= pwdata[IMAGE_HEIGHT_W-1:0];
          end
        end
        default: begin
          image_width <= image_width;
        end
      endcase
    end
  end

  // take a transfer unless the mark stage is held behind a stalled result
  assign accept = pix_valid && !pix_stall;

  bmrb_scan_ctrl #(
    .XW(XW)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .restart    (cfg_write),
    .accept     (accept),
    .pix        (pix),
    .eff_width  (eff_width),
    .eff_height (eff_height),
    .issue      (issue),
    .issue_item (issue_item),
    .issue_addr (issue_addr)
  );

  // pixels of the previous row
  bmrb_line_ram #(
    .DEPTH(MAX_WIDTH),
    .AW   (XW)
  ) u_above (
    .clk   (clk),
    .we    (above_we),
    .waddr (above_waddr),
    .wdata (above_wdata),
    .re    (issue),
    .raddr (issue_addr),
    .rdata (rd_above)
  );

  // marks of the previous row still waiting for the lower-neighbour term;
  // the last column lives in a register inside the mark stage
  bmrb_line_ram #(
    .DEPTH(MAX_WIDTH),
    .AW   (XW)
  ) u_pend (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pend_waddr),
    .wdata (pend_wdata),
    .re    (issue),
    .raddr (issue_addr),
    .rdata (rd_pend)
  );

  bmrb_mark_stage #(
    .XW(XW)
  ) u_mark (
    .clk         (clk),
    .rst         (rst),
    .issue       (issue),
    .issue_item  (issue_item),
    .issue_addr  (issue_addr),
    .rd_above    (rd_above),
    .rd_pend     (rd_pend),
    .hold        (pix_stall),
    .above_we    (above_we),
    .above_waddr (above_waddr),
    .above_wdata (above_wdata),
    .pend_we     (pend_we),
    .pend_waddr  (pend_waddr),
    .pend_wdata  (pend_wdata),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res         (res)
  );

endmodule

### design/bmrb_checker.sv
// Port-level assertions for the run-boundary unit, bound to the top level.
`timescale 1ns / 1ps

module bmrb_checker
  import bmrb_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      pix_valid,
  input logic      pix_stall,
  input logic      res_valid,
  input logic      res_stall,
  input res_item_t res
);

  // hold a stalled result unchanged
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed or dropped");

  // leave reset with an empty output and an open input
  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid && !pix_stall)
    else $error("output or stall not cleared by reset");

  // stall the input only behind a result that is itself stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pix_stall |-> res_valid && res_stall)
    else $error("input stalled without a stalled result");

  // a fresh result always follows an input transfer that passed the mark stage register
  a_res_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(pix_valid && !pix_stall, 2))
    else $error("result without a preceding transfer");

endmodule

bind binary_mask_run_boundary_unit bmrb_checker u_bmrb_checker (.*);

### sim/binary_mask_run_boundary_unit_tb.sv
// Self-checking testbench for the binary mask run-boundary unit.
`timescale 1ns / 1ps

module binary_mask_run_boundary_unit_tb;
  import bmrb_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;        // long receiver hold-off
  localparam int CYCLE_LIMIT   = 2_000_000;  // run aborts beyond this
  localparam int PRINT_LIMIT   = 40;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #10 clk = ~clk;

  // configuration port
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // pixel and result channels
  logic      pix_valid = 1'b0;
  logic      pix_stall;
  pix_item_t pix       = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_item_t res;

  binary_mask_run_boundary_unit #(
    .MAX_WIDTH(MAX_W)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix      (pix),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the block: register copies, line stores and scan position.
  // ---------------------------------------------------------------------------
  logic [IMAGE_WIDTH_W-1:0]  width_reg  = IMAGE_WIDTH_W'(WIDTH_RESET);
  logic [IMAGE_HEIGHT_W-1:0] height_reg = IMAGE_HEIGHT_W'(HEIGHT_RESET);
  bit          row_above_q [MAX_W];   // pixels of the previous row
  bit          pending_q   [MAX_W];   // marks of the previous row, lower term missing
  int unsigned col_pos    = 0;
  int unsigned row_pos    = 0;
  bit          left_q     = 1'b0;
  bit          draining_q = 1'b0;

  pix_item_t pix_backlog[$];   // items waiting for the driver
  res_item_t marks_due[$];     // results owed by the block, oldest first

  int  mismatch_count = 0;
  int  cycle_count    = 0;
  bit  random_part    = 1'b0;  // set while the random stimulus runs

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT)
      $display("%0t ns: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Register write or a slice completing: back to the top-left pixel.
  task automatic rewind_slice();
    col_pos    = 0;
    row_pos    = 0;
    left_q     = 1'b0;
    draining_q = 1'b0;
  endtask

  // Advance the shadow by one accepted item and queue the result it owes.
  task automatic trace_boundary(input pix_item_t it);
    int unsigned w, h, x;
    bit          above, first_row;
    res_item_t   mark;
    // clamp the registers to the ranges the block supports
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg);
    x = col_pos;
    if (it.opcode == OP_DRAIN) begin
      // drain before the slice's last pixel is dropped without trace
      if (draining_q) begin
        mark.boundary_mark = pending_q[x];
        mark.slice_last    = (x + 1 >= w);
        marks_due.push_back(mark);
        if (x + 1 >= w) rewind_slice();
        else col_pos = x + 1;
      end
    end else if (!draining_q) begin
      above     = row_above_q[x];
      first_row = (row_pos == 0);
      // pixel of row y > 0 settles the mark of the pixel above it
      if (!first_row) begin
        mark.boundary_mark = pending_q[x] | (above & !it.pixel_in);
        mark.slice_last    = 1'b0;
        marks_due.push_back(mark);
      end
      // a clear pixel ends the run of its left neighbour
      if (x > 0 && left_q && !it.pixel_in) pending_q[x - 1] = 1'b1;
      pending_q[x]   = it.pixel_in && (x == 0 || !left_q || first_row || !above);
      row_above_q[x] = it.pixel_in;
      left_q         = it.pixel_in;
      if (x + 1 >= w) begin
        col_pos = 0;
        left_q  = 1'b0;
        if (row_pos + 1 >= h) draining_q = 1'b1;
        else row_pos++;
      end else begin
        col_pos = x + 1;
      end
    end
  endtask

  // Per-transfer wait, alternating busy stretches and stretches with no idling.
  function automatic int unsigned next_wait(inout bit busy, inout int unsigned stretch);
    if (stretch == 0) begin
      busy    = ~busy;
      stretch = $urandom_range(8, 60);
    end
    stretch--;
    return busy ? $urandom_range(0, 15) : 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer items from the backlog, predict each one on its transfer.
  // ---------------------------------------------------------------------------
  int unsigned send_gap     = 0;
  int unsigned send_stretch = 0;
  bit          send_busy    = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
      pix       <= '0;
    end else begin
      if (pix_valid && !pix_stall) begin
        trace_boundary(pix);
        send_gap = next_wait(send_busy, send_stretch);
      end
      // hold a stalled item; otherwise idle out the gap or advance
      if (!pix_valid || !pix_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          pix_valid <= 1'b0;
        end else if (pix_backlog.size() != 0) begin
          pix       <= pix_backlog.pop_front();
          pix_valid <= 1'b1;
        end else begin
          pix_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall at random, check each result transfer against the oldest
  // expectation. Once in the random part, hold off for a long stretch so the
  // block backs up and stalls its input.
  // ---------------------------------------------------------------------------
  int unsigned stall_left     = 0;
  int unsigned hold_left      = 0;
  int unsigned recv_stretch   = 0;
  bit          recv_busy      = 1'b0;
  bit          hold_done      = 1'b0;
  int unsigned random_results = 0;

  always @(posedge clk) begin
    res_item_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (marks_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result mark=%b last=%b",
                                    res.boundary_mark, res.slice_last));
        end else begin
          want = marks_due.pop_front();
          if (res.boundary_mark !== want.boundary_mark)
            report_mismatch($sformatf("boundary_mark %b, want %b",
                                      res.boundary_mark, want.boundary_mark));
          if (res.slice_last !== want.slice_last)
            report_mismatch($sformatf("slice_last %b, want %b",
                                      res.slice_last, want.slice_last));
        end
        stall_left = next_wait(recv_busy, recv_stretch);
        if (random_part) random_results++;
      end
      if (random_part && !hold_done && random_results >= 60) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      res_stall <= (hold_left > 0) || (stall_left > 0);
      if (hold_left > 0) hold_left--;
      else if (stall_left > 0) stall_left--;
    end
  end

  // abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration access: setup then access phase. A write lands in the
  // shadow and restarts the slice; a read is compared with the given value.
  // ---------------------------------------------------------------------------
  task automatic reg_access(input logic idx, input bit is_write, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= is_write ? value : '0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (!is_write && prdata !== value)
      report_mismatch($sformatf("register %0d reads %0h, want %0h", idx, prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (is_write) begin
      if (idx == REG_IMAGE_WIDTH) width_reg = value[IMAGE_WIDTH_W-1:0];
      else height_reg = value[IMAGE_HEIGHT_W-1:0];
      rewind_slice();
    end
  endtask

  // Write both registers with junk in the unused bits, then read them back.
  task automatic set_geometry(input int unsigned w, input int unsigned h);
    logic [31:0]               junk;
    logic [IMAGE_WIDTH_W-1:0]  wf;
    logic [IMAGE_HEIGHT_W-1:0] hf;
    junk = $urandom;
    wf   = w[IMAGE_WIDTH_W-1:0];
    hf   = h[IMAGE_HEIGHT_W-1:0];
    reg_access(REG_IMAGE_WIDTH, 1'b1, {junk[31:IMAGE_WIDTH_W], wf});
    reg_access(REG_IMAGE_HEIGHT, 1'b1, {junk[31:IMAGE_HEIGHT_W], hf});
    reg_access(REG_IMAGE_WIDTH, 1'b0, 32'(wf));
    reg_access(REG_IMAGE_HEIGHT, 1'b0, 32'(hf));
  endtask

  // Wait until every item has transferred and every result has come back,
  // then let the pipeline drain of items that owe nothing.
  task automatic wait_quiet();
    do @(negedge clk);
    while (pix_backlog.size() != 0 || pix_valid || marks_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Queue one slice of random content. Fewer pixels than a full slice cut it
  // short with no drain. Sprinkle stray items and the odd short or long drain.
  task automatic queue_slice(input int unsigned w, input int unsigned h,
                             input int unsigned pixels);
    int unsigned fill, drains;
    fill = 25 * $urandom_range(0, 4);
    for (int unsigned i = 0; i < pixels; i++) begin
      if ($urandom_range(0, 24) == 0)
        pix_backlog.push_back('{opcode: OP_DRAIN, pixel_in: 1'($urandom)});
      pix_backlog.push_back('{opcode: OP_PIXEL, pixel_in: ($urandom_range(0, 99) < fill)});
    end
    if (pixels < w * h) return;
    case ($urandom_range(0, 9))
      0:       drains = w + $urandom_range(1, 3);
      1:       drains = $urandom_range(0, w - 1);
      default: drains = w;
    endcase
    for (int unsigned i = 0; i < drains; i++) begin
      if ($urandom_range(0, 15) == 0)
        pix_backlog.push_back('{opcode: OP_PIXEL, pixel_in: 1'($urandom)});
      pix_backlog.push_back('{opcode: OP_DRAIN, pixel_in: 1'($urandom)});
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned w, h, random_items;
    logic [8:0]  plate;
    random_items = 0;
    // 3x3 block, solid except for a hole in the middle of the bottom row
    plate = 9'b111_111_101;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // registers come out of reset at their documented values
    reg_access(REG_IMAGE_WIDTH, 1'b0, 32'(WIDTH_RESET));
    reg_access(REG_IMAGE_HEIGHT, 1'b0, 32'(HEIGHT_RESET));

    // Directed: runs reaching the right and bottom edges, a hole, a drain
    // before the final row, a pixel during the drain.
    set_geometry(3, 3);
    pix_backlog.push_back('{opcode: OP_DRAIN, pixel_in: 1'b1});
    for (int i = 0; i < 9; i++)
      pix_backlog.push_back('{opcode: OP_PIXEL, pixel_in: plate[8 - i]});
    pix_backlog.push_back('{opcode: OP_PIXEL, pixel_in: 1'b0});
    repeat (3) pix_backlog.push_back('{opcode: OP_DRAIN, pixel_in: 1'b0});
    wait_quiet();

    // zero width and height clamp to a single pixel
    set_geometry(0, 0);
    pix_backlog.push_back('{opcode: OP_PIXEL, pixel_in: 1'b1});
    pix_backlog.push_back('{opcode: OP_PIXEL, pixel_in: 1'b0});
    pix_backlog.push_back('{opcode: OP_DRAIN, pixel_in: 1'b1});
    pix_backlog.push_back('{opcode: OP_PIXEL, pixel_in: 1'b0});
    pix_backlog.push_back('{opcode: OP_DRAIN, pixel_in: 1'b0});
    wait_quiet();

    // Random: small geometries, a few slices each, now and then a slice cut
    // short so the next register write lands mid-slice.
    random_part = 1'b1;
    while (random_items < 800) begin
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      set_geometry(w, h);
      repeat ($urandom_range(1, 3)) begin
        queue_slice(w, h, w * h);
        random_items += w * h + w;
      end
      if ($urandom_range(0, 7) == 0) queue_slice(w, h, $urandom_range(0, w * h - 1));
      wait_quiet();
    end
    random_part = 1'b0;

    // Extremes: width above the store size and height above the limit read
    // back as written.
    set_geometry(2047, 8191);
    wait_quiet();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
